[rtl/mmm_pkg.sv]
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types for the modular matrix multiply core: controller states,
// datapath operation codes, the command bundle and register indexes.
// ----------------------------------------------------------------------------
package mmm_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_WRITE,
		S_ADDR,
		S_LATCH,
		S_MUL,
		S_ACC,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_RED_STEP,
		OP_WRITE,
		OP_READ,
		OP_LATCH,
		OP_MUL_STEP,
		OP_ACC,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic wr_right;
	} cmd_t;

	localparam logic [3:0] REG_MODULUS = 4'd0;
	localparam logic [3:0] REG_ROWS_A  = 4'd1;
	localparam logic [3:0] REG_INNER   = 4'd2;
	localparam logic [3:0] REG_COLS_B  = 4'd3;

	localparam int MUL_STEPS = 32;

endpackage

[rtl/modular_matrix_multiply_core.sv]
// ----------------------------------------------------------------------------
// modular_matrix_multiply_core
// Loads A then B one entry per request, reduced mod p, then emits every
// entry of A*B mod p in row-major order with row, column and last flag.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start & !busy          entry_value
//  result    result_valid (1 clk)   result_value, result_row, result_col,
//                                   last_entry
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
//  Each load request keeps busy high through the bit-serial reduction of
//  the entry and then the store write.
//  After the last B entry each result is built from inner_dim products:
//  per product a store read, an operand latch, the shift-add modular
//  multiplier and an accumulate; busy stays high until the last result.
//  arst_n clears the controller, the load count and the config registers
//  (modulus 2, all dimensions 8); the entry stores hold no reset value.
//  The receiver cannot stall: each result shows for exactly one cycle.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module modular_matrix_multiply_core #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] entry_value,
	output logic        result_valid,
	output logic [31:0] result_value,
	output logic [2:0]  result_row,
	output logic [2:0]  result_col,
	output logic        last_entry,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = $clog2(MAX_DIM + 1);

	logic [31:0] modulus_q;
	logic [3:0]  rows_q, inner_q, cols_q;

	logic [DW-1:0]  nr, nk, nc;
	mmm_pkg::cmd_t  cmd;
	logic [AW-1:0]  wr_addr, rd_a_addr, rd_b_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 32'd2;
			rows_q    <= 4'd8;
			inner_q   <= 4'd8;
			cols_q    <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				mmm_pkg::REG_MODULUS: modulus_q <= cfg_data;
				mmm_pkg::REG_ROWS_A:  rows_q    <= cfg_data[3:0];
				mmm_pkg::REG_INNER:   inner_q   <= cfg_data[3:0];
				mmm_pkg::REG_COLS_B:  cols_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past MAX_DIM clamps
	function automatic logic [DW-1:0] eff_dim(input logic [3:0] d);
		logic [DW-1:0] r;
		if (d == 4'd0)
			r = DW'(1);
		else if (32'(d) > MAX_DIM)
			r = DW'(MAX_DIM);
		else
			r = DW'(d);
		return r;
	endfunction

	assign nr = eff_dim(rows_q);
	assign nk = eff_dim(inner_q);
	assign nc = eff_dim(cols_q);

	mmm_ctrl #(
		.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .AW(AW), .DW(DW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.nr(nr), .nk(nk), .nc(nc),
		.busy(busy), .cmd(cmd),
		.wr_addr(wr_addr), .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
		.res_valid(result_valid), .res_row(result_row),
		.res_col(result_col), .res_last(last_entry)
	);

	// modulus zero means 2^32
	mmm_dp #(
		.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .AW(AW)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.modulus_eff(modulus_q), .modulus_wrap(modulus_q == 32'd0),
		.entry_value(entry_value),
		.wr_addr(wr_addr), .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
		.acc_value(result_value)
	);

	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside busy window");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_entry |=> !busy && !result_valid)
		else $error("activity after last result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !result_valid)
		else $error("load request not taken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		last_entry && !result_valid |-> busy)
		else $error("stray last flag");

endmodule

[rtl/mmm_dp.sv]
// ----------------------------------------------------------------------------
// mmm_dp
// Datapath: entry stores, bit-serial modular reduce and multiply unit,
// modular accumulator.
// ----------------------------------------------------------------------------
module mmm_dp #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32,
	parameter int AW         = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mmm_pkg::cmd_t  cmd,
	input  logic [31:0]    modulus_eff,
	input  logic           modulus_wrap,
	input  logic [31:0]    entry_value,
	input  logic [AW-1:0]  wr_addr,
	input  logic [AW-1:0]  rd_a_addr,
	input  logic [AW-1:0]  rd_b_addr,
	output logic [31:0]    acc_value
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [31:0] left_mem  [DEPTH];
	logic [31:0] right_mem [DEPTH];
	logic [31:0] left_rd_q, right_rd_q;

	logic [33:0] r_q;
	logic [31:0] opa_q, opb_q;
	logic [32:0] acc_q;

	logic [33:0] pm, p2, t_red, red_next, t_mul, mul_next, t_acc, acc_next;

	assign pm = {1'b0, modulus_wrap, modulus_eff};
	assign p2 = {modulus_wrap, modulus_eff, 1'b0};

	// shift one dividend bit in, conditional subtract
	assign t_red    = {r_q[32:0], opb_q[31]};
	assign red_next = (t_red >= pm) ? t_red - pm : t_red;

	// r = 2r + bit*a, result below 3p
	assign t_mul = {r_q[32:0], 1'b0} + (opb_q[31] ? {2'b00, opa_q} : 34'd0);
	always_comb begin
		if (t_mul >= p2)
			mul_next = t_mul - p2;
		else if (t_mul >= pm)
			mul_next = t_mul - pm;
		else
			mul_next = t_mul;
	end

	assign t_acc    = {1'b0, acc_q} + r_q;
	assign acc_next = (t_acc >= pm) ? t_acc - pm : t_acc;

	always_ff @(posedge clk) begin
		if (cmd.op == mmm_pkg::OP_WRITE) begin
			if (cmd.wr_right)
				right_mem[wr_addr] <= r_q[31:0];
			else
				left_mem[wr_addr] <= r_q[31:0];
		end
		if (cmd.op == mmm_pkg::OP_READ) begin
			left_rd_q  <= left_mem[rd_a_addr];
			right_rd_q <= right_mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			opa_q <= '0;
			opb_q <= '0;
			acc_q <= '0;
		end else begin
			case (cmd.op)
				mmm_pkg::OP_LOAD_IN: begin
					r_q   <= '0;
					opb_q <= entry_value << (32 - ELEM_WIDTH);
				end
				mmm_pkg::OP_RED_STEP: begin
					r_q   <= red_next;
					opb_q <= {opb_q[30:0], 1'b0};
				end
				mmm_pkg::OP_WRITE: acc_q <= '0;
				mmm_pkg::OP_LATCH: begin
					r_q   <= '0;
					opa_q <= left_rd_q;
					opb_q <= right_rd_q;
				end
				mmm_pkg::OP_MUL_STEP: begin
					r_q   <= mul_next;
					opb_q <= {opb_q[30:0], 1'b0};
				end
				mmm_pkg::OP_ACC:  acc_q <= acc_next[32:0];
				mmm_pkg::OP_EMIT: acc_q <= '0;
				default: ;
			endcase
		end
	end

	assign acc_value = acc_q[31:0];

endmodule

[rtl/mmm_ctrl.sv]
// ----------------------------------------------------------------------------
// mmm_ctrl
// Controller: load sequencing, store addressing and the i/j/k result loops.
// ----------------------------------------------------------------------------
module mmm_ctrl #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32,
	parameter int AW         = 6,
	parameter int DW         = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  nr,
	input  logic [DW-1:0]  nk,
	input  logic [DW-1:0]  nc,
	output logic           busy,
	output mmm_pkg::cmd_t  cmd,
	output logic [AW-1:0]  wr_addr,
	output logic [AW-1:0]  rd_a_addr,
	output logic [AW-1:0]  rd_b_addr,
	output logic           res_valid,
	output logic [2:0]     res_row,
	output logic [2:0]     res_col,
	output logic           res_last
);

	localparam int CW = $clog2(2 * MAX_DIM * MAX_DIM + 1);

	mmm_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] wr_addr_q, wr_addr_d;
	logic          wr_right_q, wr_right_d, pass_done_q, pass_done_d;
	logic [DW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [5:0]    step_q, step_d;

	logic [CW-1:0] na, total, cnt0, cnt_next, idx;
	logic          last_res;

	assign na       = CW'(nr) * CW'(nk);
	assign total    = na + CW'(nk) * CW'(nc);
	assign cnt0     = (cnt_q >= total) ? '0 : cnt_q;
	assign cnt_next = cnt0 + CW'(1);
	assign idx      = (cnt0 >= na) ? cnt0 - na : cnt0;
	assign last_res = (i_q == nr - DW'(1)) && (j_q == nc - DW'(1));

	assign wr_addr   = wr_addr_q;
	assign rd_a_addr = AW'(CW'(i_q) * CW'(nk) + CW'(k_q));
	assign rd_b_addr = AW'(CW'(k_q) * CW'(nc) + CW'(j_q));
	assign res_row   = 3'(i_q);
	assign res_col   = 3'(j_q);
	// flag only rides with the result strobe
	assign res_last  = last_res && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmm_pkg::S_IDLE;
			cnt_q       <= '0;
			wr_addr_q   <= '0;
			wr_right_q  <= 1'b0;
			pass_done_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			step_q      <= '0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			wr_addr_q   <= wr_addr_d;
			wr_right_q  <= wr_right_d;
			pass_done_q <= pass_done_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			step_q      <= step_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		wr_addr_d   = wr_addr_q;
		wr_right_d  = wr_right_q;
		pass_done_d = pass_done_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		step_d      = step_q;
		cmd.op       = mmm_pkg::OP_NONE;
		cmd.wr_right = wr_right_q;
		busy         = 1'b1;
		res_valid    = 1'b0;
		case (state_q)
			mmm_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op      = mmm_pkg::OP_LOAD_IN;
					wr_addr_d   = AW'(idx);
					wr_right_d  = (cnt0 >= na);
					pass_done_d = (cnt_next == total);
					cnt_d       = (cnt_next == total) ? '0 : cnt_next;
					step_d      = '0;
					state_d     = mmm_pkg::S_RED;
				end
			end
			mmm_pkg::S_RED: begin
				cmd.op = mmm_pkg::OP_RED_STEP;
				step_d = step_q + 6'd1;
				if (step_q == 6'(ELEM_WIDTH - 1))
					state_d = mmm_pkg::S_WRITE;
			end
			mmm_pkg::S_WRITE: begin
				cmd.op = mmm_pkg::OP_WRITE;
				i_d    = '0;
				j_d    = '0;
				k_d    = '0;
				state_d = pass_done_q ? mmm_pkg::S_ADDR : mmm_pkg::S_IDLE;
			end
			mmm_pkg::S_ADDR: begin
				cmd.op  = mmm_pkg::OP_READ;
				state_d = mmm_pkg::S_LATCH;
			end
			mmm_pkg::S_LATCH: begin
				cmd.op  = mmm_pkg::OP_LATCH;
				step_d  = '0;
				state_d = mmm_pkg::S_MUL;
			end
			mmm_pkg::S_MUL: begin
				cmd.op = mmm_pkg::OP_MUL_STEP;
				step_d = step_q + 6'd1;
				if (step_q == 6'(mmm_pkg::MUL_STEPS - 1))
					state_d = mmm_pkg::S_ACC;
			end
			mmm_pkg::S_ACC: begin
				cmd.op = mmm_pkg::OP_ACC;
				if (k_q == nk - DW'(1)) begin
					state_d = mmm_pkg::S_EMIT;
				end else begin
					k_d     = k_q + DW'(1);
					state_d = mmm_pkg::S_ADDR;
				end
			end
			mmm_pkg::S_EMIT: begin
				cmd.op    = mmm_pkg::OP_EMIT;
				res_valid = 1'b1;
				k_d       = '0;
				if (last_res) begin
					state_d = mmm_pkg::S_IDLE;
				end else begin
					state_d = mmm_pkg::S_ADDR;
					if (j_q == nc - DW'(1)) begin
						j_d = '0;
						i_d = i_q + DW'(1);
					end else begin
						j_d = j_q + DW'(1);
					end
				end
			end
			default: state_d = mmm_pkg::S_IDLE;
		endcase
	end

endmodule
